// ----- sv/csem_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csem_pkg: shared types and constants for the counting semaphore
// Operation and result codes, count limits and the control/status bundles
// passed between the controller and the datapath.
// ----------------------------------------------------------------------------
package csem_pkg;

    localparam int CountW  = 16;
    localparam int InitW   = 15;
    localparam int ModeW   = 2;
    localparam int TidW    = 8;
    localparam int StatusW = 4;
    localparam int RetW    = 2;

    localparam logic signed [CountW-1:0] CountMax  = 16'sh7FFF;
    localparam logic signed [CountW-1:0] CountMin  = 16'sh8000;
    localparam logic signed [CountW-1:0] CountZero = 16'sh0000;
    localparam logic signed [CountW-1:0] CountOne  = 16'sh0001;

    localparam logic signed [RetW-1:0] RetNormal = 2'sb00;
    localparam logic signed [RetW-1:0] RetTryOk  = 2'sb01;
    localparam logic signed [RetW-1:0] RetClosed = 2'sb11;

    typedef enum logic [ModeW-1:0] {
        MODE_WAIT   = 2'd0,
        MODE_SIGNAL = 2'd1,
        MODE_TRY    = 2'd2,
        MODE_CLOSE  = 2'd3
    } mode_t;

    typedef enum logic [StatusW-1:0] {
        ST_ACQUIRED      = 4'd0,
        ST_BLOCKED       = 4'd1,
        ST_WOKE          = 4'd2,
        ST_NO_WAITER     = 4'd3,
        ST_TRY_OK        = 4'd4,
        ST_TRY_FAIL      = 4'd5,
        ST_CLOSED_WAITER = 4'd6,
        ST_CLOSED_EMPTY  = 4'd7,
        ST_FULL          = 4'd8
    } status_t;

    typedef enum logic [1:0] {
        CS_IDLE  = 2'd0,
        CS_EXEC  = 2'd1,
        CS_DRAIN = 2'd2
    } ctrl_state_t;

    typedef struct packed {
        logic load;
        logic exec;
        logic drain;
    } dp_cmd_t;

    typedef struct packed {
        logic is_close;
        logic queue_empty;
        logic queue_last;
        logic out_busy;
    } dp_sts_t;

endpackage

// ----- sv/csem_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csem_ram: generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module csem_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- sv/csem_dp.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csem_dp: semaphore datapath
// Holds the count, the wait queue pointers and occupancy, the queue RAM,
// the initial count register and the result register.
// ----------------------------------------------------------------------------
module csem_dp
    import csem_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [InitW-1:0]         cfg_wdata,
    input  logic [ModeW-1:0]         mode,
    input  logic [TidW-1:0]          thread_id,
    input  dp_cmd_t                  cmd,
    output dp_sts_t                  sts,
    input  logic                     out_stall,
    output logic                     out_valid,
    output logic [StatusW-1:0]       status,
    output logic [TidW-1:0]          released_thread,
    output logic signed [RetW-1:0]   waiter_return,
    output logic signed [CountW-1:0] count_now,
    output logic                     last
);

    localparam int PtrW = $clog2(QUEUE_DEPTH);
    localparam int OccW = $clog2(QUEUE_DEPTH + 1);
    localparam int IdW  = THREAD_ID_BITS;

    logic [InitW-1:0]         init_reg;
    mode_t                    op_reg;
    logic [IdW-1:0]           tid_reg;
    logic signed [CountW-1:0] count_reg, count_next;
    logic [PtrW-1:0]          head_reg, head_next;
    logic [PtrW-1:0]          tail_reg, tail_next;
    logic [OccW-1:0]          occ_reg, occ_next;

    logic                     out_valid_reg;
    status_t                  status_reg, status_next;
    logic [TidW-1:0]          thread_reg, thread_next;
    logic signed [RetW-1:0]   ret_reg, ret_next;
    logic signed [CountW-1:0] cnt_out_reg, cnt_out_next;
    logic                     last_reg, last_next;

    logic                     ram_we;
    logic [IdW-1:0]           ram_rdata;
    logic signed [CountW-1:0] cnt_inc, cnt_dec, init_cnt;
    logic                     q_empty, q_full, q_last, out_load;

    function automatic logic [PtrW-1:0] next_slot(input logic [PtrW-1:0] p);
        next_slot = (p == PtrW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    csem_ram #(
        .WIDTH (IdW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .we    (ram_we),
        .waddr (tail_reg),
        .wdata (tid_reg),
        .raddr (head_next),
        .rdata (ram_rdata)
    );

    assign q_empty  = (occ_reg == '0);
    assign q_full   = (occ_reg >= OccW'(QUEUE_DEPTH));
    assign q_last   = (occ_reg == OccW'(1));
    assign out_load = cmd.exec | cmd.drain;

    assign cnt_inc  = (count_reg < CountMax) ? count_reg + CountOne : count_reg;
    assign cnt_dec  = (count_reg > CountMin) ? count_reg - CountOne : count_reg;
    assign init_cnt = signed'({1'b0, init_reg});

    assign sts.is_close    = (op_reg == MODE_CLOSE);
    assign sts.queue_empty = q_empty;
    assign sts.queue_last  = q_last;
    assign sts.out_busy    = out_valid_reg & out_stall;

    always_comb
    begin
        count_next   = count_reg;
        head_next    = head_reg;
        tail_next    = tail_reg;
        occ_next     = occ_reg;
        ram_we       = 1'b0;
        status_next  = ST_NO_WAITER;
        thread_next  = '0;
        ret_next     = RetNormal;
        cnt_out_next = count_reg;
        last_next    = 1'b1;
        if (cmd.exec)
        begin
            case (op_reg)
                MODE_WAIT:
                begin
                    if (count_reg <= CountZero && q_full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        count_next   = cnt_dec;
                        cnt_out_next = cnt_dec;
                        if (cnt_dec < CountZero)
                        begin
                            ram_we      = 1'b1;
                            tail_next   = next_slot(tail_reg);
                            occ_next    = occ_reg + 1'b1;
                            status_next = ST_BLOCKED;
                        end
                        else
                        begin
                            status_next = ST_ACQUIRED;
                        end
                    end
                end
                MODE_SIGNAL:
                begin
                    count_next   = cnt_inc;
                    cnt_out_next = cnt_inc;
                    if (cnt_inc <= CountZero && !q_empty)
                    begin
                        status_next = ST_WOKE;
                        thread_next = TidW'(ram_rdata);
                        head_next   = next_slot(head_reg);
                        occ_next    = occ_reg - 1'b1;
                    end
                end
                MODE_TRY:
                begin
                    if (count_reg > CountZero)
                    begin
                        count_next   = cnt_dec;
                        cnt_out_next = cnt_dec;
                        status_next  = ST_TRY_OK;
                        ret_next     = RetTryOk;
                    end
                    else
                    begin
                        status_next = ST_TRY_FAIL;
                    end
                end
                MODE_CLOSE:
                begin
                    count_next   = init_cnt;
                    cnt_out_next = init_cnt;
                    head_next    = '0;
                    tail_next    = '0;
                    status_next  = ST_CLOSED_EMPTY;
                end
                default:
                begin
                    status_next = ST_NO_WAITER;
                end
            endcase
        end
        else if (cmd.drain)
        begin
            status_next = ST_CLOSED_WAITER;
            thread_next = TidW'(ram_rdata);
            ret_next    = RetClosed;
            head_next   = next_slot(head_reg);
            occ_next    = occ_reg - 1'b1;
            if (q_last)
            begin
                count_next   = init_cnt;
                cnt_out_next = init_cnt;
                head_next    = '0;
                tail_next    = '0;
            end
            else
            begin
                last_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg      <= '0;
            count_reg     <= CountZero;
            head_reg      <= '0;
            tail_reg      <= '0;
            occ_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                init_reg <= cfg_wdata;
            end
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            occ_reg   <= occ_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // hold the operation and the result payload
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg  <= mode_t'(mode);
            tid_reg <= IdW'(thread_id);
        end
        if (out_load)
        begin
            status_reg  <= status_next;
            thread_reg  <= thread_next;
            ret_reg     <= ret_next;
            cnt_out_reg <= cnt_out_next;
            last_reg    <= last_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign released_thread = thread_reg;
    assign waiter_return   = ret_reg;
    assign count_now       = cnt_out_reg;
    assign last            = last_reg;

`ifndef ASSERT_OFF
    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= OccW'(QUEUE_DEPTH))
        else $error("queue occupancy above depth");

    a_waiters_negative: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg != '0 |-> count_reg < CountZero)
        else $error("waiters queued while count is not negative");

    a_close_resets_queue: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.drain && q_last |=> occ_reg == '0 && head_reg == '0 && tail_reg == '0)
        else $error("queue not cleared after final close transfer");
`endif

endmodule

// ----- sv/csem_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// csem_ctrl: semaphore controller
// Sequences accept, execute and close drain, and pauses while the result
// register is held.
// ----------------------------------------------------------------------------
module csem_ctrl
    import csem_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    in_valid,
    output logic    in_stall,
    output dp_cmd_t cmd,
    input  dp_sts_t sts
);

    ctrl_state_t state_reg, state_next;
    logic        drain_start;

    assign drain_start = sts.is_close & ~sts.queue_empty;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                if (!sts.out_busy)
                begin
                    if (drain_start && !sts.queue_last)
                    begin
                        state_next = CS_DRAIN;
                    end
                    else
                    begin
                        state_next = CS_IDLE;
                    end
                end
            end
            CS_DRAIN:
            begin
                if (!sts.out_busy && sts.queue_last)
                begin
                    state_next = CS_IDLE;
                end
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_stall  = 1'b1;
        cmd.load  = 1'b0;
        cmd.exec  = 1'b0;
        cmd.drain = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                in_stall = 1'b0;
                cmd.load = in_valid;
            end
            CS_EXEC:
            begin
                if (!sts.out_busy)
                begin
                    cmd.exec  = ~drain_start;
                    cmd.drain = drain_start;
                end
            end
            CS_DRAIN:
            begin
                cmd.drain = ~sts.out_busy;
            end
            default:
            begin
                in_stall = 1'b1;
            end
        endcase
    end

`ifndef ASSERT_OFF
    a_drain_has_waiter: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == CS_DRAIN |-> sts.is_close && !sts.queue_empty)
        else $error("close drain with an empty queue");

    a_exec_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.exec |=> state_reg == CS_IDLE)
        else $error("single-result operation did not return to idle");

    a_no_cmd_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        sts.out_busy |-> !cmd.exec && !cmd.drain)
        else $error("result register overwritten while held");
`endif

endmodule

// ----- sv/counting_semaphore_wait_queue.sv -----
// An accepted item's operation is registered, then executed in the EXEC state into the result register.
// The accept/execute controller takes a new item only when idle, after the previous one has executed.
// Close with N queued waiters gives N transfers, one per cycle while the output is not stalled,
// as the queue RAM yields one entry per read.
// Reset: count and initial_count clear to 0, queue empty, no result pending.
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// counting_semaphore_wait_queue: counting semaphore with FIFO wait queue
// Executes wait, signal, trywait and close operations and reports the
// released thread, return code and count for each result transfer.
// ----------------------------------------------------------------------------
module counting_semaphore_wait_queue
    import csem_pkg::*;
#(
    parameter int QUEUE_DEPTH    = 16,
    parameter int THREAD_ID_BITS = 8
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [InitW-1:0]         cfg_wdata,
    input  logic                     in_valid,
    output logic                     in_stall,
    input  logic [ModeW-1:0]         mode,
    input  logic [TidW-1:0]          thread_id,
    output logic                     out_valid,
    input  logic                     out_stall,
    output logic [StatusW-1:0]       status,
    output logic [TidW-1:0]          released_thread,
    output logic signed [RetW-1:0]   waiter_return,
    output logic signed [CountW-1:0] count_now,
    output logic                     last
);

    dp_cmd_t cmd;
    dp_sts_t sts;

    csem_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .cmd      (cmd),
        .sts      (sts)
    );

    csem_dp #(
        .QUEUE_DEPTH    (QUEUE_DEPTH),
        .THREAD_ID_BITS (THREAD_ID_BITS)
    ) u_dp (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_wdata       (cfg_wdata),
        .mode            (mode),
        .thread_id       (thread_id),
        .cmd             (cmd),
        .sts             (sts),
        .out_stall       (out_stall),
        .out_valid       (out_valid),
        .status          (status),
        .released_thread (released_thread),
        .waiter_return   (waiter_return),
        .count_now       (count_now),
        .last            (last)
    );

endmodule

// ----- test/semaphore_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// semaphore_checker: result predictor and comparator for the semaphore
// Tracks the initial count register, the semaphore count and the FIFO of
// blocked thread ids from every accepted transfer, and compares each result
// transfer field by field against the oldest predicted reply.
// ----------------------------------------------------------------------------
module semaphore_checker
    import csem_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [InitW-1:0]         cfg_wdata,
    input  logic                     in_valid,
    input  logic                     in_stall,
    input  logic [ModeW-1:0]         mode,
    input  logic [TidW-1:0]          thread_id,
    input  logic                     out_valid,
    input  logic                     out_stall,
    input  logic [StatusW-1:0]       status,
    input  logic [TidW-1:0]          released_thread,
    input  logic signed [RetW-1:0]   waiter_return,
    input  logic signed [CountW-1:0] count_now,
    input  logic                     last,
    output int                       mismatches,
    output int                       replies_outstanding
);

    typedef struct {
        status_t                  status;
        logic [TidW-1:0]          thread;
        logic signed [RetW-1:0]   ret;
        logic signed [CountW-1:0] count;
        logic                     last;
    } sem_reply_t;

    sem_reply_t               replies_due[$];
    logic [InitW-1:0]         init_count;
    logic signed [CountW-1:0] sem_count;
    logic [TidW-1:0]          waiters[QUEUE_DEPTH];
    int unsigned              wq_head;
    int unsigned              wq_tail;
    int unsigned              wq_fill;

    task automatic queue_reply(status_t s, logic [TidW-1:0] t,
                               logic signed [RetW-1:0] r, logic final_flag);
        sem_reply_t rep;
        rep.status = s;
        rep.thread = t;
        rep.ret    = r;
        rep.count  = sem_count;
        rep.last   = final_flag;
        replies_due.push_back(rep);
    endtask

    task automatic apply_operation(mode_t op, logic [TidW-1:0] tid);
        logic [TidW-1:0] who;
        case (op)
            MODE_WAIT:
                if (sem_count <= CountZero && wq_fill >= QUEUE_DEPTH) begin
                    queue_reply(ST_FULL, '0, RetNormal, 1'b1);
                end else begin
                    if (sem_count != CountMin)
                        sem_count = sem_count - CountOne;
                    if (sem_count < CountZero) begin
                        waiters[wq_tail] = tid;
                        wq_tail = (wq_tail + 1) % QUEUE_DEPTH;
                        wq_fill++;
                        queue_reply(ST_BLOCKED, '0, RetNormal, 1'b1);
                    end else begin
                        queue_reply(ST_ACQUIRED, '0, RetNormal, 1'b1);
                    end
                end
            MODE_SIGNAL:
            begin
                if (sem_count != CountMax)
                    sem_count = sem_count + CountOne;
                if (sem_count <= CountZero && wq_fill > 0) begin
                    who = waiters[wq_head];
                    wq_head = (wq_head + 1) % QUEUE_DEPTH;
                    wq_fill--;
                    queue_reply(ST_WOKE, who, RetNormal, 1'b1);
                end else begin
                    queue_reply(ST_NO_WAITER, '0, RetNormal, 1'b1);
                end
            end
            MODE_TRY:
                if (sem_count > CountZero) begin
                    sem_count = sem_count - CountOne;
                    queue_reply(ST_TRY_OK, '0, RetTryOk, 1'b1);
                end else begin
                    queue_reply(ST_TRY_FAIL, '0, RetNormal, 1'b1);
                end
            default:
            begin
                if (wq_fill == 0) begin
                    sem_count = {1'b0, init_count};
                    queue_reply(ST_CLOSED_EMPTY, '0, RetNormal, 1'b1);
                end
                while (wq_fill > 0) begin
                    who = waiters[wq_head];
                    wq_head = (wq_head + 1) % QUEUE_DEPTH;
                    wq_fill--;
                    if (wq_fill == 0)
                        sem_count = {1'b0, init_count};
                    queue_reply(ST_CLOSED_WAITER, who, RetClosed, wq_fill == 0);
                end
                wq_head = 0;
                wq_tail = 0;
            end
        endcase
    endtask

    task automatic check_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin : track
        sem_reply_t want;
        if (!rst_n) begin
            init_count = '0;
            sem_count  = CountZero;
            wq_head    = 0;
            wq_tail    = 0;
            wq_fill    = 0;
            mismatches = 0;
            replies_due.delete();
            replies_outstanding <= 0;
        end else begin
            if (cfg_we)
                init_count = cfg_wdata;
            if (out_valid && !out_stall) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: unexpected result, expected none, got status %0d thread %0d",
                             $time, status, released_thread);
                    mismatches++;
                end else begin
                    want = replies_due.pop_front();
                    check_field("status", want.status, status);
                    check_field("released_thread", want.thread, released_thread);
                    check_field("waiter_return", want.ret, waiter_return);
                    check_field("count_now", want.count, count_now);
                    check_field("last", want.last, last);
                end
            end
            if (in_valid && !in_stall)
                apply_operation(mode_t'(mode), thread_id);
            replies_outstanding <= replies_due.size();
        end
    end

endmodule

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: testbench for the counting semaphore with FIFO wait queue
// Drives directed operations (try on empty, acquire, block up to a full
// queue, wake, close with and without waiters, count saturation) and random
// phases under varied sender idling and receiver stalling, with the initial
// count reprogrammed between phases; the checker predicts every result.
// ----------------------------------------------------------------------------
module tb;
    import csem_pkg::*;

    localparam int QueueDepth = 16;

    logic                     clk       = 1'b0;
    logic                     rst_n     = 1'b0;
    logic                     cfg_we    = 1'b0;
    logic [InitW-1:0]         cfg_wdata = '0;
    logic                     in_valid  = 1'b0;
    logic                     in_stall;
    logic [ModeW-1:0]         mode      = MODE_WAIT;
    logic [TidW-1:0]          thread_id = '0;
    logic                     out_valid;
    logic                     out_stall = 1'b0;
    logic [StatusW-1:0]       status;
    logic [TidW-1:0]          released_thread;
    logic signed [RetW-1:0]   waiter_return;
    logic signed [CountW-1:0] count_now;
    logic                     last;

    int mismatches;
    int replies_outstanding;
    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;

    counting_semaphore_wait_queue #(
        .QUEUE_DEPTH   (QueueDepth),
        .THREAD_ID_BITS(TidW)
    ) dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .thread_id      (thread_id),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .status         (status),
        .released_thread(released_thread),
        .waiter_return  (waiter_return),
        .count_now      (count_now),
        .last           (last)
    );

    semaphore_checker #(
        .QUEUE_DEPTH(QueueDepth)
    ) sem_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .cfg_we             (cfg_we),
        .cfg_wdata          (cfg_wdata),
        .in_valid           (in_valid),
        .in_stall           (in_stall),
        .mode               (mode),
        .thread_id          (thread_id),
        .out_valid          (out_valid),
        .out_stall          (out_stall),
        .status             (status),
        .released_thread    (released_thread),
        .waiter_return      (waiter_return),
        .count_now          (count_now),
        .last               (last),
        .mismatches         (mismatches),
        .replies_outstanding(replies_outstanding)
    );

    always #4 clk = ~clk;

    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(99) < receiver_stall_pct);
    end

    task automatic transfer_op(mode_t op, logic [TidW-1:0] tid);
        while ($urandom_range(99) < sender_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        mode      <= op;
        thread_id <= tid;
        do @(posedge clk); while (in_stall);
    endtask

    task automatic drain_replies();
        in_valid <= 1'b0;
        do @(posedge clk); while (replies_outstanding != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_initial_count(logic [InitW-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic random_op(int wait_pct);
        int    r;
        mode_t op;
        r = $urandom_range(99);
        if (r < wait_pct)
            op = MODE_WAIT;
        else if (r < wait_pct + 24)
            op = MODE_SIGNAL;
        else if (r < 94)
            op = MODE_TRY;
        else
            op = MODE_CLOSE;
        transfer_op(op, TidW'($urandom_range(255)));
    endtask

    initial begin
        #2_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int phase;
        int blk;
        int i;
        logic [InitW-1:0] init_value;

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        // the register write must leave the live count alone until close
        write_initial_count(15'd5);
        transfer_op(MODE_TRY, 8'h00);
        transfer_op(MODE_SIGNAL, 8'hFF);
        transfer_op(MODE_TRY, 8'h5A);
        transfer_op(MODE_SIGNAL, 8'h3C);
        transfer_op(MODE_WAIT, 8'hC3);
        for (i = 0; i < QueueDepth; i++)
            transfer_op(MODE_WAIT, (i == 0) ? 8'hFF : (i == 1) ? 8'h00
                                   : TidW'($urandom_range(255)));
        transfer_op(MODE_WAIT, 8'h77);
        transfer_op(MODE_SIGNAL, 8'h11);
        transfer_op(MODE_CLOSE, 8'hA5);
        transfer_op(MODE_CLOSE, 8'h5A);

        for (phase = 0; phase < 4; phase++) begin
            drain_replies();
            case (phase)
                0: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct <= 0;
                    init_value = 15'h7FFF;
                end
                1: begin
                    sender_idle_pct = 78;
                    receiver_stall_pct <= 0;
                    init_value = 15'd0;
                end
                2: begin
                    sender_idle_pct = 0;
                    receiver_stall_pct <= 78;
                    init_value = InitW'($urandom_range(1, 3));
                end
                default: begin
                    sender_idle_pct = 12;
                    receiver_stall_pct <= 12;
                    init_value = InitW'($urandom_range(0, 2));
                end
            endcase
            write_initial_count(init_value);
            transfer_op(MODE_CLOSE, TidW'($urandom_range(255)));
            if (phase == 0) begin
                transfer_op(MODE_SIGNAL, 8'hFF);
                transfer_op(MODE_TRY, 8'h00);
            end
            for (blk = 0; blk < 2; blk++)
                for (i = 0; i < 16; i++)
                    random_op((blk == 0) ? 60 : 30);
        end

        drain_replies();
        if (mismatches == 0 && replies_outstanding == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
